>>> design/dss_pkg.sv
`default_nettype none

package dss_pkg;

   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int VALUE_WIDTH = 13;
   localparam int SWITCH_WIDTH = 16;
   localparam int POS_WIDTH = 3;

   localparam logic OP_SWITCH = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [7:0] SEG_BLANK = 8'hff;
   localparam logic [7:0] ANODE_RESET = 8'hbf;
   localparam logic [7:0] DIGIT_RESET = 8'h00;

   typedef struct packed {
      logic busy;
      logic done;
   } conv_stat_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pat;
      case (digit)
         4'd0: pat = 8'hc0;
         4'd1: pat = 8'hf9;
         4'd2: pat = 8'ha4;
         4'd3: pat = 8'hb0;
         4'd4: pat = 8'h99;
         4'd5: pat = 8'h92;
         4'd6: pat = 8'h82;
         4'd7: pat = 8'hf8;
         4'd8: pat = 8'h80;
         4'd9: pat = 8'h90;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

   function automatic logic [7:0] start_lookup(input logic [POS_WIDTH-1:0] pos);
      logic [7:0] pat;
      case (pos)
         3'd1: pat = 8'hef;
         3'd2: pat = 8'hf7;
         3'd3: pat = 8'hfb;
         3'd4: pat = 8'hfd;
         3'd5: pat = 8'hfe;
         default: pat = SEG_BLANK;
      endcase
      return pat;
   endfunction

endpackage

`default_nettype wire

>>> design/dss_bcd_conv.sv
`default_nettype none

module dss_bcd_conv
   import dss_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [VALUE_WIDTH-1:0]     value,
   output conv_stat_type                   stat,
   output logic      [4*DIGIT_COUNT-1:0]   bcd
);

   localparam int BCD_WIDTH = 4 * DIGIT_COUNT;
   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [BCD_WIDTH-1:0]   bcd_ff, bcd_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [BCD_WIDTH-1:0]   adjusted;

   always_comb begin
      logic [3:0] digit;
      digit = 4'd0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         digit = bcd_ff[i*4 +: 4];
         adjusted[i*4 +: 4] = (digit >= 4'd5) ? digit + 4'd3 : digit;
      end
   end

   always_comb begin
      value_in = value_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         value_in = value;
         bcd_in   = '0;
         count_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         // shift one bit in, add-3 correction per digit
         bcd_in   = {adjusted[BCD_WIDTH-2:0], value_ff[VALUE_WIDTH-1]};
         value_in = {value_ff[VALUE_WIDTH-2:0], 1'b0};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign bcd       = bcd_ff;

endmodule

`default_nettype wire

>>> design/decimal_seven_segment_scanner.sv
`default_nettype none

// channel   direction  handshake             payload
// req_      in         req_valid/req_stall   req_opcode, req_switches
// rsp_      out        rsp_valid/rsp_stall   rsp_anodes, rsp_segments
//
// A tick item's result sits in the output register.
// A switch item runs a load, one pass of the shared add-3/shift unit per bit of the 13-bit
// value and a write of the digit patterns; req_stall stays high meanwhile.
// Reset is synchronous: digit patterns clear, the scan starts at anodes 0xbf.
// An item waits while a result is held by rsp_stall.

module decimal_seven_segment_scanner
   import dss_pkg::*;
#(
   parameter int DIGIT_COUNT = DIGIT_COUNT_DEFAULT
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_stall,
   input  wire logic                    req_opcode,
   input  wire logic [SWITCH_WIDTH-1:0] req_switches,
   output logic                         rsp_valid,
   input  wire logic                    rsp_stall,
   output logic      [7:0]              rsp_anodes,
   output logic      [7:0]              rsp_segments
);

   localparam int IDX_WIDTH = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam logic [15:0] ONES_WIDE = (16'd1 << DIGIT_COUNT) - 16'd1;
   localparam logic [7:0] LOW_ONES = ONES_WIDE[7:0];

   logic [7:0]           digit_patterns_ff [DIGIT_COUNT];
   logic [IDX_WIDTH-1:0] scan_index_ff, scan_index_in;
   logic [7:0]           anode_pattern_ff, anode_pattern_in;
   logic [7:0]           start_pattern_ff;
   logic                 busy_ff;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_anodes_ff;
   logic [7:0]           rsp_segments_ff;

   logic                      accept;
   logic                      accept_switch;
   logic                      accept_tick;
   logic [7:0]                shifted;
   logic [15:0]               start_wide;
   logic [7:0]                wrap_pattern;
   logic [7:0]                start_new;
   conv_stat_type             conv_stat;
   logic [4*DIGIT_COUNT-1:0]  conv_bcd;

   assign req_stall     = busy_ff | (rsp_valid_ff & rsp_stall);
   assign accept        = req_valid & ~req_stall;
   assign accept_switch = accept & (req_opcode == OP_SWITCH);
   assign accept_tick   = accept & (req_opcode == OP_TICK);

   dss_bcd_conv #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_conv (
      .clock(clock),
      .reset(reset),
      .start(accept_switch),
      .value(req_switches[SWITCH_WIDTH-1:POS_WIDTH]),
      .stat (conv_stat),
      .bcd  (conv_bcd)
   );

   assign start_new    = start_lookup(req_switches[POS_WIDTH-1:0]);
   assign start_wide   = {8'h00, start_pattern_ff} << DIGIT_COUNT;
   assign wrap_pattern = start_wide[7:0] | LOW_ONES;
   assign shifted      = {anode_pattern_ff[6:0], 1'b1};

   always_comb begin
      scan_index_in    = scan_index_ff;
      anode_pattern_in = anode_pattern_ff;
      if (accept_switch) begin
         scan_index_in    = '0;
         anode_pattern_in = start_new;
      end else if (accept_tick) begin
         if (scan_index_ff == IDX_WIDTH'(DIGIT_COUNT - 1)) begin
            scan_index_in = '0;
         end else begin
            scan_index_in = scan_index_ff + 1'b1;
         end
         anode_pattern_in = (shifted == wrap_pattern) ? start_pattern_ff : shifted;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIGIT_COUNT; i++) begin
            digit_patterns_ff[i] <= DIGIT_RESET;
         end
         scan_index_ff    <= '0;
         anode_pattern_ff <= ANODE_RESET;
         start_pattern_ff <= DIGIT_RESET;
         busy_ff          <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         scan_index_ff    <= scan_index_in;
         anode_pattern_ff <= anode_pattern_in;
         if (accept_switch) begin
            start_pattern_ff <= start_new;
            busy_ff          <= 1'b1;
         end else if (conv_stat.done) begin
            busy_ff <= 1'b0;
         end
         if (conv_stat.done) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
               digit_patterns_ff[i] <= seg_pattern(conv_bcd[i*4 +: 4]);
            end
         end
         if (accept_tick) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_tick) begin
         rsp_anodes_ff   <= anode_pattern_ff;
         rsp_segments_ff <= digit_patterns_ff[scan_index_ff];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_anodes   = rsp_anodes_ff;
   assign rsp_segments = rsp_segments_ff;

`ifndef NO_ASSERTIONS
   a_switch_busy: assert property (@(posedge clock) disable iff (reset)
      accept_switch |=> busy_ff)
      else $error("switch item did not start conversion");

   a_conv_in_busy: assert property (@(posedge clock) disable iff (reset)
      (conv_stat.busy || conv_stat.done) |-> busy_ff)
      else $error("conversion active outside busy window");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      accept_tick |=> rsp_valid_ff)
      else $error("tick item produced no result");

   a_no_tick_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !accept)
      else $error("item accepted during conversion");
`endif

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`default_nettype none

module tb_top;
   import dss_pkg::*;

   localparam int DIGITS = DIGIT_COUNT_DEFAULT;
   localparam int ITEM_TARGET = 750;
   localparam int LONG_HOLD = 400;
   localparam logic [7:0] GLYPH [0:9] = '{
      8'hc0, 8'hf9, 8'ha4, 8'hb0, 8'h99, 8'h92, 8'h82, 8'hf8, 8'h80, 8'h90
   };
   localparam logic [7:0] START_CODE [0:7] = '{
      8'hff, 8'hef, 8'hf7, 8'hfb, 8'hfd, 8'hfe, 8'hff, 8'hff
   };

   typedef struct packed {
      logic                    opcode;
      logic [SWITCH_WIDTH-1:0] switches;
      logic                    no_gap;
      logic                    drain;
   } scan_item_type;

   typedef struct packed {
      logic [7:0] anodes;
      logic [7:0] segments;
   } scan_view_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic                    req_opcode = OP_SWITCH;
   logic [SWITCH_WIDTH-1:0] req_switches = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic [7:0]              rsp_anodes;
   logic [7:0]              rsp_segments;

   scan_item_type pending_items[$];
   scan_view_type expected_scan[$];
   scan_item_type cur_item;

   logic [7:0] digit_pat [0:DIGITS-1];
   int         scan_pos;
   logic [7:0] anode_cur;
   logic [7:0] start_cur;

   int gap_left;
   int hold_left;
   int switch_count;
   int tick_count;
   int scan_checked;
   int error_count;

   decimal_seven_segment_scanner #(
      .DIGIT_COUNT(DIGITS)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_switches(req_switches),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_anodes(rsp_anodes),
      .rsp_segments(rsp_segments)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic scan_predict(input scan_item_type it);
      int unsigned   value;
      scan_view_type view;
      logic [7:0]    wrap_pat;
      if (it.opcode == OP_SWITCH) begin
         value = {19'd0, it.switches[15:3]};
         for (int i = 0; i < DIGITS; i++) begin
            digit_pat[i] = GLYPH[value % 10];
            value = value / 10;
         end
         start_cur = START_CODE[it.switches[2:0]];
         anode_cur = start_cur;
         scan_pos = 0;
      end else begin
         view.anodes = anode_cur;
         view.segments = digit_pat[scan_pos];
         expected_scan.push_back(view);
         scan_pos = (scan_pos == DIGITS - 1) ? 0 : scan_pos + 1;
         anode_cur = {anode_cur[6:0], 1'b1};
         wrap_pat = (start_cur << DIGITS) | 8'((1 << DIGITS) - 1);
         if (anode_cur == wrap_pat)
            anode_cur = start_cur;
      end
   endtask

   task automatic add_item(input logic op, input logic [SWITCH_WIDTH-1:0] sw,
                           input logic no_gap, input logic drain);
      scan_item_type it;
      it.opcode = op;
      it.switches = sw;
      it.no_gap = no_gap;
      it.drain = drain;
      pending_items.push_back(it);
   endtask

   task automatic add_ticks(input int n, input logic no_gap);
      for (int i = 0; i < n; i++)
         add_item(OP_TICK, SWITCH_WIDTH'($urandom_range(0, 65535)), no_gap, 1'b0);
   endtask

   // driver: offer pending items, hold a drain item until all results are in
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_opcode <= OP_SWITCH;
         req_switches <= '0;
         gap_left = 0;
         for (int i = 0; i < DIGITS; i++)
            digit_pat[i] = DIGIT_RESET;
         scan_pos = 0;
         anode_cur = ANODE_RESET;
         start_cur = 8'h00;
      end else begin
         if (req_valid && !req_stall) begin
            scan_predict(cur_item);
            if (cur_item.opcode == OP_SWITCH)
               switch_count++;
            else
               tick_count++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_items.size() != 0 &&
                         !(pending_items[0].drain && expected_scan.size() != 0)) begin
               cur_item = pending_items.pop_front();
               req_valid <= 1'b1;
               req_opcode <= cur_item.opcode;
               req_switches <= cur_item.switches;
               gap_left = cur_item.no_gap ? 0 : $urandom_range(0, 19);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each result, then draw the stall before the next one
   always @(posedge clock) begin
      scan_view_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_scan.size() == 0) begin
               $error("unexpected result: anodes %h segments %h", rsp_anodes, rsp_segments);
               error_count++;
            end else begin
               want = expected_scan.pop_front();
               if (rsp_anodes !== want.anodes) begin
                  $error("anodes: expected %h, got %h", want.anodes, rsp_anodes);
                  error_count++;
               end
               if (rsp_segments !== want.segments) begin
                  $error("segments: expected %h, got %h", want.segments, rsp_segments);
                  error_count++;
               end
            end
            scan_checked++;
            if (scan_checked == 150)
               hold_left = LONG_HOLD;
            else if (scan_checked % 100 < 30)
               hold_left = 0;
            else
               hold_left = $urandom_range(0, 19);
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   initial begin
      logic [SWITCH_WIDTH-1:0] sw;
      logic                    burst;
      switch_count = 0;
      tick_count = 0;
      scan_checked = 0;
      error_count = 0;

      // scan from reset state, no switch word yet
      add_ticks(3, 1'b0);
      add_item(OP_SWITCH, {13'd1234, 3'd1}, 1'b0, 1'b0);
      add_ticks(5, 1'b1);
      add_item(OP_SWITCH, {13'h1fff, 3'd5}, 1'b0, 1'b0);
      add_ticks(5, 1'b0);
      add_item(OP_SWITCH, {13'd0, 3'd0}, 1'b0, 1'b0);
      add_ticks(2, 1'b0);
      add_item(OP_SWITCH, {13'd7, 3'd6}, 1'b0, 1'b0);
      add_ticks(1, 1'b0);
      add_item(OP_SWITCH, {13'd42, 3'd7}, 1'b0, 1'b1);
      add_ticks(1, 1'b0);

      while (pending_items.size() < ITEM_TARGET) begin
         sw = SWITCH_WIDTH'($urandom_range(0, 65535));
         if ($urandom_range(0, 3) != 0)
            sw[2:0] = 3'($urandom_range(1, 5));
         case ($urandom_range(0, 9))
            0: sw[15:3] = 13'h1fff;
            1: sw[15:3] = 13'($urandom_range(0, 9));
            2, 3: sw[15:3] = 13'($urandom_range(0, 1200));
            default: ;
         endcase
         burst = ($urandom_range(0, 5) == 0);
         add_item(OP_SWITCH, sw, burst, $urandom_range(0, 29) == 0);
         add_ticks($urandom_range(0, 10), burst);
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_scan.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);

      $display("run covered %0d switch words and %0d scan ticks, %0d results checked",
               switch_count, tick_count, scan_checked);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2000000;
      $display("timeout with %0d results still expected", expected_scan.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule

`default_nettype wire
